FILE: design/centroid_track_table_core_macros.svh
// Assertion helpers shared by the track table RTL
`ifndef CENTROID_TRACK_TABLE_CORE_MACROS_SVH
`define CENTROID_TRACK_TABLE_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define CTT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("track table check failed");

// Check that cons holds in the cycle after ante
`define CTT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("track table check failed");

`endif

FILE: design/ctt_pkg.sv
`default_nettype none

package ctt_pkg;

   // table geometry and field widths
   localparam int TRACKS     = 16;
   localparam int TRACK_BITS = $clog2(TRACKS);
   localparam int COORD_BITS = 12;
   localparam int ID_BITS    = 16;
   localparam int CNT_BITS   = 8;
   localparam int DIST_BITS  = 12;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int SUM_BITS   = SQ_BITS + 1;
   localparam int LIM_BITS   = 2 * DIST_BITS;
   localparam int BEST_BITS  = (SUM_BITS > LIM_BITS) ? SUM_BITS : LIM_BITS;

   // configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 12;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DROP_AGE     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MATCH_RADIUS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONFIRM_HITS = 2'd2;

   localparam logic [CNT_BITS-1:0]  DROP_AGE_RST     = 8'd10;
   localparam logic [DIST_BITS-1:0] MATCH_RADIUS_RST = 12'd60;
   localparam logic [CNT_BITS-1:0]  CONFIRM_HITS_RST = 8'd10;

   // input word kinds
   localparam logic KIND_CENTER = 1'b0;
   localparam logic KIND_EOF    = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
   } ctt_req_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    track_id;
      logic [COORD_BITS-1:0] track_x;
      logic [COORD_BITS-1:0] track_y;
      logic [CNT_BITS-1:0]   lost_count;
      logic [CNT_BITS-1:0]   found_count;
      logic                  none_confirmed;
      logic                  dropped_new;
      logic                  last;
   } ctt_rsp_type;

   // one slot of the table memory
   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [CNT_BITS-1:0]   lost;
      logic [CNT_BITS-1:0]   found;
   } ctt_entry_type;

   localparam int ENTRY_BITS = $bits(ctt_entry_type);

   // slot read back from memory, handed to the distance unit
   typedef struct packed {
      logic                  vld;
      logic                  elig;
      logic [TRACK_BITS-1:0] idx;
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      ctt_entry_type         entry;
   } ctt_probe_type;

   // scored slot coming out of the distance unit
   typedef struct packed {
      logic                  vld;
      logic                  elig;
      logic [TRACK_BITS-1:0] idx;
      logic [ID_BITS-1:0]    id;
      logic [CNT_BITS-1:0]   found;
      logic [SUM_BITS-1:0]   sqd;
   } ctt_cand_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DET_SCAN,
      ST_DET_WAIT,
      ST_DET_WR,
      ST_EOF_RD,
      ST_EOF_EV,
      ST_EOF_FL
   } ctt_state_type;

endpackage

`default_nettype wire

FILE: design/ctt_ram.sv
`default_nettype none

module ctt_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 56
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, hold data when not reading
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: design/ctt_dist.sv
`default_nettype none

module ctt_dist
   import ctt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctt_probe_type probe,
   output ctt_cand_type       cand
);

   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;

   logic                  a_vld_ff;
   logic                  a_elig_ff;
   logic [TRACK_BITS-1:0] a_idx_ff;
   logic [ID_BITS-1:0]    a_id_ff;
   logic [CNT_BITS-1:0]   a_found_ff;
   logic [SQ_BITS-1:0]    a_sqx_ff;
   logic [SQ_BITS-1:0]    a_sqy_ff;

   ctt_cand_type          cand_ff;

   // absolute coordinate differences
   always_comb begin
      dx = (probe.cx > probe.entry.x) ? probe.cx - probe.entry.x : probe.entry.x - probe.cx;
      dy = (probe.cy > probe.entry.y) ? probe.cy - probe.entry.y : probe.entry.y - probe.cy;
   end

   // stage A: square each difference
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= probe.vld;
      end
      a_elig_ff  <= probe.elig;
      a_idx_ff   <= probe.idx;
      a_id_ff    <= probe.entry.id;
      a_found_ff <= probe.entry.found;
      a_sqx_ff   <= SQ_BITS'(dx) * SQ_BITS'(dx);
      a_sqy_ff   <= SQ_BITS'(dy) * SQ_BITS'(dy);
   end

   // stage B: sum the squares
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.vld <= 1'b0;
      end else begin
         cand_ff.vld <= a_vld_ff;
      end
      cand_ff.elig  <= a_elig_ff;
      cand_ff.idx   <= a_idx_ff;
      cand_ff.id    <= a_id_ff;
      cand_ff.found <= a_found_ff;
      cand_ff.sqd   <= SUM_BITS'(a_sqx_ff) + SUM_BITS'(a_sqy_ff);
   end

   assign cand = cand_ff;

endmodule

`default_nettype wire

FILE: design/centroid_track_table_core.sv
`default_nettype none
// Centroid track table.
// req channel: one word per detection center (kind 0) or end of frame (kind 1).
// rsp channel: result words, produced only at end of frame, one per confirmed
//   track in slot order, or a single none_confirmed word; last marks the final.
// csr channel: register writes (drop age, match radius, confirm hits), taken every cycle.
// Timing: the slot entries sit in one single-port-read table memory, so every
//   word walks the table one slot at a time through that read port.
//   A center passes through the slot reads, the memory read register, the two
//   distance stages and one write-back.
//   An end of frame reads and updates each slot in turn, then does a final flush,
//   and holds while a result cannot be placed because rsp_ready is low.
// req_ready is high only while the table is not busy with a word; a result
//   still waiting in the output register does not block it.
// When the receiver stalls, the frame walk holds at the slot whose result
//   cannot be placed; the table is not touched until it moves on.
// Reset: all slots invalid, next id zero, drop flag clear, registers at
//   their defaults, output register empty.
`include "centroid_track_table_core_macros.svh"

module centroid_track_table_core
   import ctt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire ctt_req_type              req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output ctt_rsp_type                   rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam logic [TRACK_BITS-1:0] LAST_SLOT = TRACK_BITS'(TRACKS - 1);

   ctt_state_type          state_ff, state_in;

   // configuration
   logic [CNT_BITS-1:0]    drop_age_ff;
   logic [DIST_BITS-1:0]   match_radius_ff;
   logic [CNT_BITS-1:0]    confirm_hits_ff;
   logic [LIM_BITS-1:0]    limit_ff;

   // per-slot flags
   logic [TRACKS-1:0]      valid_ff;
   logic [TRACKS-1:0]      old_ff;
   logic [TRACKS-1:0]      matched_ff;

   logic [ID_BITS-1:0]     next_id_ff;
   logic                   drop_flag_ff;
   logic                   drop_ff;

   // walk state
   logic [TRACK_BITS-1:0]  slot_ff;
   logic [COORD_BITS-1:0]  cx_ff;
   logic [COORD_BITS-1:0]  cy_ff;
   logic                   det_rd_ff;
   logic [TRACK_BITS-1:0]  rd_idx_ff;

   // search results
   logic [BEST_BITS-1:0]   best_ff;
   logic                   pick_hit_ff;
   logic [TRACK_BITS-1:0]  pick_idx_ff;
   logic [ID_BITS-1:0]     pick_id_ff;
   logic [CNT_BITS-1:0]    pick_found_ff;
   logic                   free_hit_ff;
   logic [TRACK_BITS-1:0]  free_idx_ff;

   // result held back until the next confirmed slot shows whether it is last
   logic                   pend_vld_ff;
   ctt_entry_type          pend_ff;

   logic                   rsp_valid_ff;
   ctt_rsp_type            rsp_data_ff;

   // memory ports
   logic                   rd_en;
   logic [TRACK_BITS-1:0]  rd_addr;
   logic [ENTRY_BITS-1:0]  rd_data;
   logic                   wr_en;
   logic [TRACK_BITS-1:0]  wr_addr;
   ctt_entry_type          wr_data;
   ctt_entry_type          rd_entry;

   ctt_probe_type          probe;
   ctt_cand_type           cand;

   // datapath helpers
   logic                   req_acc;
   logic                   out_free;
   logic                   out_push;
   ctt_rsp_type            out_data;
   logic [CNT_BITS:0]      found_inc;
   logic [CNT_BITS-1:0]    found_new;
   logic                   ev_valid;
   logic                   ev_age;
   logic [CNT_BITS:0]      ev_lost_inc;
   logic                   ev_free;
   logic                   ev_keep;
   logic                   ev_conf;
   logic                   ev_stall;
   ctt_entry_type          ev_entry;

   ctt_ram #(
      .DEPTH (TRACKS),
      .WIDTH (ENTRY_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry = ctt_entry_type'(rd_data);

   // feed read-back slots of a center search to the distance unit
   always_comb begin
      probe.vld   = det_rd_ff;
      probe.elig  = valid_ff[rd_idx_ff] & old_ff[rd_idx_ff] & ~matched_ff[rd_idx_ff];
      probe.idx   = rd_idx_ff;
      probe.cx    = cx_ff;
      probe.cy    = cy_ff;
      probe.entry = rd_entry;
   end

   ctt_dist u_dist (
      .clock (clock),
      .reset (reset),
      .probe (probe),
      .cand  (cand)
   );

   assign req_acc   = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // found count of a matched track, capped at the confirm hit count
   always_comb begin
      found_inc = (CNT_BITS + 1)'(pick_found_ff) + (CNT_BITS + 1)'(1);
      if (found_inc > (CNT_BITS + 1)'(confirm_hits_ff)) begin
         found_new = confirm_hits_ff;
      end else begin
         found_new = found_inc[CNT_BITS-1:0];
      end
   end

   // age one slot at end of frame
   always_comb begin
      ev_valid    = valid_ff[slot_ff];
      ev_age      = old_ff[slot_ff] & ~matched_ff[slot_ff];
      ev_lost_inc = (CNT_BITS + 1)'(rd_entry.lost) + (CNT_BITS + 1)'(1);
      ev_free     = ev_valid & ev_age & (ev_lost_inc >= (CNT_BITS + 1)'(drop_age_ff));
      ev_keep     = ev_valid & ~ev_free;
      ev_entry    = rd_entry;
      if (ev_age) begin
         ev_entry.lost = ev_lost_inc[CNT_BITS-1:0];
      end
      ev_conf  = ev_keep & (rd_entry.found >= confirm_hits_ff);
      ev_stall = ev_conf & pend_vld_ff & ~out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (req_data.kind == KIND_EOF) ? ST_EOF_RD : ST_DET_SCAN;
            end
         end
         ST_DET_SCAN: begin
            if (slot_ff == LAST_SLOT) begin
               state_in = ST_DET_WAIT;
            end
         end
         ST_DET_WAIT: begin
            if (cand.vld && cand.idx == LAST_SLOT) begin
               state_in = ST_DET_WR;
            end
         end
         ST_DET_WR: begin
            state_in = ST_IDLE;
         end
         ST_EOF_RD: begin
            state_in = ST_EOF_EV;
         end
         ST_EOF_EV: begin
            if (!ev_stall) begin
               state_in = (slot_ff == LAST_SLOT) ? ST_EOF_FL : ST_EOF_RD;
            end
         end
         ST_EOF_FL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = slot_ff;
      wr_en     = 1'b0;
      wr_addr   = slot_ff;
      wr_data   = ev_entry;
      out_push  = 1'b0;
      out_data  = '0;
      out_data.track_id    = pend_ff.id;
      out_data.track_x     = pend_ff.x;
      out_data.track_y     = pend_ff.y;
      out_data.lost_count  = pend_ff.lost;
      out_data.found_count = pend_ff.found;
      out_data.dropped_new = drop_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_DET_SCAN, ST_EOF_RD: begin
            rd_en = 1'b1;
         end
         ST_DET_WAIT: begin
         end
         ST_DET_WR: begin
            if (pick_hit_ff) begin
               wr_en         = 1'b1;
               wr_addr       = pick_idx_ff;
               wr_data.id    = pick_id_ff;
               wr_data.x     = cx_ff;
               wr_data.y     = cy_ff;
               wr_data.lost  = '0;
               wr_data.found = found_new;
            end else if (free_hit_ff) begin
               wr_en         = 1'b1;
               wr_addr       = free_idx_ff;
               wr_data.id    = next_id_ff;
               wr_data.x     = cx_ff;
               wr_data.y     = cy_ff;
               wr_data.lost  = '0;
               wr_data.found = '0;
            end
         end
         ST_EOF_EV: begin
            if (!ev_stall) begin
               wr_en    = ev_keep & ev_age;
               out_push = ev_conf & pend_vld_ff;
            end
         end
         ST_EOF_FL: begin
            out_push      = out_free;
            out_data.last = 1'b1;
            if (!pend_vld_ff) begin
               out_data                = '0;
               out_data.none_confirmed = 1'b1;
               out_data.dropped_new    = drop_ff;
               out_data.last           = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_age_ff     <= DROP_AGE_RST;
         match_radius_ff <= MATCH_RADIUS_RST;
         confirm_hits_ff <= CONFIRM_HITS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DROP_AGE:     drop_age_ff     <= csr_data[CNT_BITS-1:0];
            CSR_MATCH_RADIUS: match_radius_ff <= csr_data[DIST_BITS-1:0];
            CSR_CONFIRM_HITS: confirm_hits_ff <= csr_data[CNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // squared match limit
   always_ff @(posedge clock) begin
      limit_ff <= LIM_BITS'(match_radius_ff) * LIM_BITS'(match_radius_ff);
   end

   // capture center, advance slot walk
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         det_rd_ff <= 1'b0;
      end else begin
         det_rd_ff <= (state_ff == ST_DET_SCAN);
         if (req_acc) begin
            slot_ff <= '0;
         end else if (state_ff == ST_DET_SCAN) begin
            slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         end else if (state_ff == ST_EOF_EV && !ev_stall && slot_ff != LAST_SLOT) begin
            slot_ff <= slot_ff + 1'b1;
         end
      end
      rd_idx_ff <= slot_ff;
      if (req_acc) begin
         cx_ff <= req_data.center_x;
         cy_ff <= req_data.center_y;
      end
   end

   // track nearest eligible slot and lowest free slot
   always_ff @(posedge clock) begin
      if (req_acc) begin
         pick_hit_ff <= 1'b0;
         free_hit_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DET_SCAN && slot_ff == '0) begin
            // load the squared limit as the scan starts
            best_ff <= BEST_BITS'(limit_ff);
         end else if (cand.vld && cand.elig && BEST_BITS'(cand.sqd) < best_ff) begin
            best_ff       <= BEST_BITS'(cand.sqd);
            pick_hit_ff   <= 1'b1;
            pick_idx_ff   <= cand.idx;
            pick_id_ff    <= cand.id;
            pick_found_ff <= cand.found;
         end
         if (state_ff == ST_DET_SCAN && !valid_ff[slot_ff] && !free_hit_ff) begin
            free_hit_ff <= 1'b1;
            free_idx_ff <= slot_ff;
         end
      end
   end

   // slot flags, id counter, drop flag, held result
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         old_ff       <= '0;
         matched_ff   <= '0;
         next_id_ff   <= '0;
         drop_flag_ff <= 1'b0;
         drop_ff      <= 1'b0;
         pend_vld_ff  <= 1'b0;
      end else begin
         if (req_acc && req_data.kind == KIND_EOF) begin
            drop_ff      <= drop_flag_ff;
            drop_flag_ff <= 1'b0;
         end
         if (state_ff == ST_DET_WR) begin
            if (pick_hit_ff) begin
               matched_ff[pick_idx_ff] <= 1'b1;
            end else if (free_hit_ff) begin
               valid_ff[free_idx_ff]   <= 1'b1;
               old_ff[free_idx_ff]     <= 1'b0;
               matched_ff[free_idx_ff] <= 1'b0;
               next_id_ff              <= next_id_ff + 1'b1;
            end else begin
               drop_flag_ff <= 1'b1;
            end
         end
         if (state_ff == ST_EOF_EV && !ev_stall) begin
            if (ev_valid) begin
               valid_ff[slot_ff]   <= ev_keep;
               matched_ff[slot_ff] <= 1'b0;
               old_ff[slot_ff]     <= 1'b1;
            end
            if (ev_conf) begin
               pend_vld_ff <= 1'b1;
            end
         end
         if (state_ff == ST_EOF_FL && out_free) begin
            pend_vld_ff <= 1'b0;
         end
      end
      if (state_ff == ST_EOF_EV && !ev_stall && ev_conf) begin
         pend_ff <= ev_entry;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_push) begin
         rsp_data_ff <= out_data;
      end
   end

   // no held result may survive into an idle table
   `CTT_ASSERT_IMP(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_vld_ff)
   // memory is written only at the end of a search or during aging
   `CTT_ASSERT_IMP(a_wr_state, clock, reset, wr_en, state_ff == ST_DET_WR || state_ff == ST_EOF_EV)
   // opening a track uses up exactly one id
   `CTT_ASSERT_NXT(a_id_step, clock, reset, state_ff == ST_DET_WR && !pick_hit_ff && free_hit_ff, next_id_ff == ID_BITS'($past(next_id_ff) + 1'b1))

endmodule

`default_nettype wire

FILE: test/tb_centroid_track_table_core.sv
`timescale 1ns / 1ps

module tb_centroid_track_table_core;
   import ctt_pkg::*;

   localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
   localparam int SCENE_OBJS = 8;
   localparam int PHASES     = 7;
   localparam int STALL_LEN  = 400;
   localparam int SETTLE     = 60;

   // clock and DUT ports
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   ctt_req_type              req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   ctt_rsp_type              rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   centroid_track_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the track table and registers
   bit                    trk_valid   [TRACKS];
   bit                    trk_matched [TRACKS];
   bit                    trk_aged    [TRACKS];
   logic [ID_BITS-1:0]    trk_id      [TRACKS];
   logic [COORD_BITS-1:0] trk_x       [TRACKS];
   logic [COORD_BITS-1:0] trk_y       [TRACKS];
   int unsigned           trk_lost    [TRACKS];
   int unsigned           trk_found   [TRACKS];
   logic [ID_BITS-1:0]    next_id = '0;
   bit                    new_dropped = 1'b0;
   logic [CNT_BITS-1:0]   cfg_drop_age     = DROP_AGE_RST;
   logic [DIST_BITS-1:0]  cfg_match_radius = MATCH_RADIUS_RST;
   logic [CNT_BITS-1:0]   cfg_confirm_hits = CONFIRM_HITS_RST;

   ctt_req_type pending_words [$];
   ctt_rsp_type expected_tracks [$];
   ctt_rsp_type want;
   int          words_queued = 0;
   int          words_sent = 0;
   int          error_count = 0;
   int          send_gap_pct = 0;
   int          recv_gap_pct = 0;
   bit          stall_toggle = 1'b0;
   bit          stall_seen = 1'b0;
   int          stall_left = 0;

   // scene of moving objects that feeds the random frames
   bit obj_live [SCENE_OBJS];
   int obj_x    [SCENE_OBJS];
   int obj_y    [SCENE_OBJS];

   // match a center to the nearest old unmatched track, else open a track in a free slot, else flag the drop
   task automatic place_center(input logic [COORD_BITS-1:0] cx,
                               input logic [COORD_BITS-1:0] cy);
      longint      limit, best, dx, dy, d;
      int          pick, i;
      int unsigned f;
      limit = longint'(cfg_match_radius) * longint'(cfg_match_radius);
      best  = limit;
      pick  = -1;
      for (i = 0; i < TRACKS; i++) begin
         if (!trk_valid[i] || !trk_aged[i] || trk_matched[i])
            continue;
         dx = (cx > trk_x[i]) ? longint'(cx) - longint'(trk_x[i])
                              : longint'(trk_x[i]) - longint'(cx);
         dy = (cy > trk_y[i]) ? longint'(cy) - longint'(trk_y[i])
                              : longint'(trk_y[i]) - longint'(cy);
         d = dx * dx + dy * dy;
         if (d < best) begin
            best = d;
            pick = i;
         end
      end
      if (pick >= 0) begin
         f = trk_found[pick] + 1;
         if (f > cfg_confirm_hits)
            f = cfg_confirm_hits;
         trk_x[pick]       = cx;
         trk_y[pick]       = cy;
         trk_lost[pick]    = 0;
         trk_found[pick]   = f;
         trk_matched[pick] = 1'b1;
         return;
      end
      for (i = 0; i < TRACKS; i++) begin
         if (trk_valid[i])
            continue;
         trk_valid[i]   = 1'b1;
         trk_matched[i] = 1'b0;
         trk_aged[i]    = 1'b0;
         trk_id[i]      = next_id;
         trk_x[i]       = cx;
         trk_y[i]       = cy;
         trk_lost[i]    = 0;
         trk_found[i]   = 0;
         next_id        = next_id + 1'b1;
         return;
      end
      new_dropped = 1'b1;
   endtask

   // age unmatched tracks, then list confirmed tracks in slot order
   task automatic close_frame();
      int          i, n, k;
      int unsigned l;
      bit          drop;
      ctt_rsp_type w;
      for (i = 0; i < TRACKS; i++) begin
         if (!trk_valid[i])
            continue;
         if (trk_aged[i] && !trk_matched[i]) begin
            l = trk_lost[i] + 1;
            if (l >= cfg_drop_age) begin
               trk_valid[i] = 1'b0;
               continue;
            end
            trk_lost[i] = l;
         end
         trk_matched[i] = 1'b0;
         trk_aged[i]    = 1'b1;
      end
      drop        = new_dropped;
      new_dropped = 1'b0;
      n = 0;
      for (i = 0; i < TRACKS; i++)
         if (trk_valid[i] && trk_found[i] >= cfg_confirm_hits)
            n++;
      k = 0;
      for (i = 0; i < TRACKS; i++) begin
         if (!trk_valid[i] || trk_found[i] < cfg_confirm_hits)
            continue;
         w             = '0;
         w.track_id    = trk_id[i];
         w.track_x     = trk_x[i];
         w.track_y     = trk_y[i];
         w.lost_count  = trk_lost[i][CNT_BITS-1:0];
         w.found_count = trk_found[i][CNT_BITS-1:0];
         w.dropped_new = drop;
         w.last        = (k == n - 1);
         expected_tracks = {expected_tracks, w};
         k++;
      end
      if (n == 0) begin
         w                = '0;
         w.none_confirmed = 1'b1;
         w.dropped_new    = drop;
         w.last           = 1'b1;
         expected_tracks = {expected_tracks, w};
      end
   endtask

   task automatic track_word(input ctt_req_type w);
      if (w.kind == KIND_CENTER)
         place_center(w.center_x, w.center_y);
      else
         close_frame();
   endtask

   task automatic check_field(input string name, input logic [ID_BITS-1:0] exp_v,
                              input logic [ID_BITS-1:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
         error_count++;
      end
   endtask

   // driver: advance to the next pending word once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_word(req_data);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold, counted here
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (stall_toggle != stall_seen) begin
         stall_seen <= stall_toggle;
         stall_left <= STALL_LEN;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // monitor: compare each result word with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tracks.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_tracks.pop_front();
               check_field("track_id", want.track_id, rsp_data.track_id);
               check_field("track_x", want.track_x, rsp_data.track_x);
               check_field("track_y", want.track_y, rsp_data.track_y);
               check_field("lost_count", want.lost_count, rsp_data.lost_count);
               check_field("found_count", want.found_count, rsp_data.found_count);
               check_field("none_confirmed", want.none_confirmed, rsp_data.none_confirmed);
               check_field("dropped_new", want.dropped_new, rsp_data.dropped_new);
               check_field("last", want.last, rsp_data.last);
            end
         end
         rsp_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_gap_pct);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DROP_AGE:     cfg_drop_age     = val[CNT_BITS-1:0];
         CSR_MATCH_RADIUS: cfg_match_radius = val[DIST_BITS-1:0];
         CSR_CONFIRM_HITS: cfg_confirm_hits = val[CNT_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic push_center(input int x, input int y);
      ctt_req_type w;
      w.kind     = KIND_CENTER;
      w.center_x = COORD_BITS'(x);
      w.center_y = COORD_BITS'(y);
      pending_words = {pending_words, w};
      words_queued++;
   endtask

   task automatic push_eof();
      ctt_req_type w;
      w.kind     = KIND_EOF;
      w.center_x = COORD_BITS'($urandom);
      w.center_y = COORD_BITS'($urandom);
      pending_words = {pending_words, w};
      words_queued++;
   endtask

   task automatic push_noise();
      push_center($urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
   endtask

   // one frame: jittered scene objects, some noise, rarely a burst that overflows
   task automatic add_frame(input int step);
      int start, k, i, nx, ny, live;
      if ($urandom_range(99) >= 5) begin
         start = $urandom_range(SCENE_OBJS - 1);
         for (k = 0; k < SCENE_OBJS; k++) begin
            i = (start + k) % SCENE_OBJS;
            if (!obj_live[i])
               continue;
            nx = obj_x[i] + int'($urandom_range(2 * step)) - step;
            ny = obj_y[i] + int'($urandom_range(2 * step)) - step;
            obj_x[i] = (nx < 0) ? 0 : (nx > COORD_MAX) ? COORD_MAX : nx;
            obj_y[i] = (ny < 0) ? 0 : (ny > COORD_MAX) ? COORD_MAX : ny;
            if ($urandom_range(99) < 85)
               push_center(obj_x[i], obj_y[i]);
         end
         if ($urandom_range(99) < 15)
            push_noise();
         if ($urandom_range(99) < 4)
            repeat (18) push_noise();
      end
      push_eof();
      live = 0;
      for (i = 0; i < SCENE_OBJS; i++) begin
         if (obj_live[i] && $urandom_range(99) < 4)
            obj_live[i] = 1'b0;
         live += obj_live[i];
      end
      for (i = 0; i < SCENE_OBJS; i++) begin
         if (!obj_live[i] && live < 7 && $urandom_range(99) < 8) begin
            obj_live[i] = 1'b1;
            obj_x[i]    = $urandom_range(COORD_MAX);
            obj_y[i]    = $urandom_range(COORD_MAX);
            live++;
         end
      end
   endtask

   task automatic wait_idle();
      while (words_sent != words_queued || expected_tracks.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // phases: register settings, idle mix and stimulus
   initial begin
      int p_lost [PHASES];
      int p_dist [PHASES];
      int p_min  [PHASES];
      int p, i, goal, step;
      p_lost = '{1, 3, 0, 255, 10, 4, 5};
      p_dist = '{1, 60, 4095, 200, 20, 0, 100};
      p_min  = '{0, 2, 1, 255, 3, 0, 4};
      for (i = 0; i < TRACKS; i++) begin
         trk_valid[i]   = 1'b0;
         trk_matched[i] = 1'b0;
         trk_aged[i]    = 1'b0;
         trk_id[i]      = '0;
         trk_x[i]       = '0;
         trk_y[i]       = '0;
         trk_lost[i]    = 0;
         trk_found[i]   = 0;
      end
      for (i = 0; i < SCENE_OBJS; i++) begin
         obj_live[i] = 1'b0;
         obj_x[i]    = 0;
         obj_y[i]    = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (p = 0; p < PHASES; p++) begin
         if (p <= 2) begin
            send_gap_pct <= 13;
            recv_gap_pct <= 70;
         end else if (p <= 4) begin
            send_gap_pct <= 70;
            recv_gap_pct <= 13;
         end else begin
            send_gap_pct <= 0;
            recv_gap_pct <= 0;
         end
         // upper nibble on the 8-bit registers must be ignored
         write_reg(CSR_DROP_AGE, {4'($urandom_range(15)), 8'(p_lost[p])});
         write_reg(CSR_MATCH_RADIUS, 12'(p_dist[p]));
         write_reg(CSR_CONFIRM_HITS, {4'($urandom_range(15)), 8'(p_min[p])});
         @(negedge clock);
         if (p == 0) begin
            // empty table, overflow by one, exact-position match, aging out
            push_eof();
            push_center(0, 0);
            push_center(COORD_MAX, COORD_MAX);
            push_center(0, COORD_MAX);
            push_center(COORD_MAX, 0);
            for (i = 0; i < 13; i++)
               push_center((i * 311 + 97) % (COORD_MAX + 1),
                           (i * 1283 + 41) % (COORD_MAX + 1));
            push_eof();
            push_center(0, 0);
            push_eof();
            push_eof();
         end else begin
            if (p == 2) begin
               // equal distance to two old tracks goes to the lower slot
               push_center(100, 100);
               push_center(300, 100);
               push_eof();
               push_center(200, 100);
               push_eof();
            end
            step = (p_dist[p] == 0) ? 8 : (p_dist[p] / 3 > 300) ? 300 :
                   (p_dist[p] / 3 < 1) ? 1 : p_dist[p] / 3;
            goal = words_queued + 56;
            while (words_queued < goal)
               add_frame(step);
            if (p == 5)
               stall_toggle <= ~stall_toggle;
         end
         wait_idle();
      end
      error_count += expected_tracks.size();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: centroid_track_table_core.f
+incdir+design
design/ctt_pkg.sv
design/ctt_ram.sv
design/ctt_dist.sv
design/centroid_track_table_core.sv
test/tb_centroid_track_table_core.sv
